@@ hdl/cbr_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cbr_pkg
// Shared types and constants of the BLE response reassembler.
// ----------------------------------------------------------------------------
package cbr_pkg;

  // Fragment size limits, in bytes including header bytes
  localparam int unsigned MAX_FRAGMENT_SIZE = 512;
  localparam int unsigned MIN_FRAGMENT_SIZE = 4;

  localparam int unsigned POS_W     = 10;
  localparam int unsigned LEN_W     = 16;
  localparam int unsigned SEQ_W     = 7;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DAT_W = 16;

  localparam logic [POS_W-1:0] POS_MAX       = {POS_W{1'b1}};
  localparam logic [POS_W-1:0] FRAG_SIZE_MIN = POS_W'(MIN_FRAGMENT_SIZE);
  localparam logic [POS_W-1:0] FRAG_SIZE_MAX = POS_W'(MAX_FRAGMENT_SIZE);

  // Register reset values
  localparam logic [POS_W-1:0] FRAG_SIZE_RST = 10'd20;
  localparam logic [LEN_W-1:0] MAX_LEN_RST   = 16'd1024;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FRAGMENT_SIZE   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_MESSAGE_LEN = 1'b1;

  // Command bytes
  localparam logic [7:0] CMD_KEEPALIVE = 8'h82;
  localparam logic [7:0] CMD_MSG       = 8'h83;

  // Result status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_BAD_CMD = 2'd1;
  localparam logic [1:0] ST_SHORT   = 2'd2;
  localparam logic [1:0] ST_SEQ     = 2'd3;

  typedef enum logic [2:0] {
    PH_IDLE      = 3'd0,
    PH_LEN_HI    = 3'd1,
    PH_LEN_LO    = 3'd2,
    PH_INIT_DATA = 3'd3,
    PH_CONT_SEQ  = 3'd4,
    PH_CONT_DATA = 3'd5,
    PH_DRAIN     = 3'd6
  } phase_t;

endpackage
`default_nettype wire

@@ hdl/ctap_ble_reassembler_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ctap_ble_reassembler_unit
// Reassembles CTAP2 BLE response fragments into a stream of payload bytes.
// ----------------------------------------------------------------------------
// Feed received fragment bytes one word per cycle on the in_ stream, with
// in_tlast marking the last byte of each fragment. Every accepted word yields
// exactly one result word on the out_ stream: out_tuser flags a payload byte,
// and the result also carries message-done, a status code and, on completion,
// the clamped declared length. Throughput is one byte per cycle while the sink
// keeps up: the byte's state update and result are computed in one pass into
// the result register, and a new byte is taken whenever that register is
// empty or being drained in the same cycle. Keepalive fragments
// are skipped, short fragments, bad commands and sequence mismatches return
// an error status and rearm for a new initial fragment. Write the two
// configuration registers only while the stream is idle; a write takes effect
// on the next byte.
module ctap_ble_reassembler_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // configuration write port
  input  wire logic        cfg_wr_en,
  input  wire logic [0:0]  cfg_index,
  input  wire logic [15:0] cfg_wdata,
  // received fragment bytes
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,    // [7:0] data_byte
  input  wire logic        in_tlast,    // frag_end
  // results
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata,   // [7:0] payload_byte, [8] msg_done,
                                        // [10:9] status, [26:11] msg_length
  output logic             out_tuser    // payload_valid
);

  localparam int unsigned PW = cbr_pkg::POS_W;
  localparam int unsigned LW = cbr_pkg::LEN_W;
  localparam int unsigned SW = cbr_pkg::SEQ_W;

  // configuration
  logic [PW-1:0] frag_size_r;
  logic [LW-1:0] max_len_r;

  // reassembly state
  cbr_pkg::phase_t phase_r, phase_nxt;
  logic [PW-1:0]   frag_pos_r, frag_pos_nxt;
  logic [LW-1:0]   remaining_r, remaining_nxt;
  logic [LW-1:0]   total_len_r, total_len_nxt;
  logic [SW-1:0]   exp_seq_r, exp_seq_nxt;
  logic            skip_ka_r, skip_ka_nxt;

  // result register
  logic          out_valid_r;
  logic [7:0]    pbyte_r, pbyte_nxt;
  logic          pvalid_r, pvalid_nxt;
  logic          done_r, done_nxt;
  logic [1:0]    status_r, status_nxt;
  logic [LW-1:0] mlen_r, mlen_nxt;

  logic          accept;
  logic [PW-1:0] fsize;
  logic [LW-1:0] len_lo;
  logic          fin;

  // Take a new byte whenever the result register frees up this cycle
  assign in_tready = !out_valid_r || out_tready;
  assign accept    = in_tvalid && in_tready;

  // Clamp the fragment size into its legal range
  always_comb begin
    priority if (frag_size_r < cbr_pkg::FRAG_SIZE_MIN) begin
      fsize = cbr_pkg::FRAG_SIZE_MIN;
    end else if (frag_size_r > cbr_pkg::FRAG_SIZE_MAX) begin
      fsize = cbr_pkg::FRAG_SIZE_MAX;
    end else begin
      fsize = frag_size_r;
    end
  end

  assign len_lo = {total_len_r[LW-1:8], in_tdata};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frag_size_r <= cbr_pkg::FRAG_SIZE_RST;
      max_len_r   <= cbr_pkg::MAX_LEN_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        cbr_pkg::REG_FRAGMENT_SIZE:   frag_size_r <= cfg_wdata[PW-1:0];
        cbr_pkg::REG_MAX_MESSAGE_LEN: max_len_r   <= cfg_wdata[LW-1:0];
        default: ;
      endcase
    end
  end

  // Per-byte state update and result
  always_comb begin
    phase_nxt     = phase_r;
    remaining_nxt = remaining_r;
    total_len_nxt = total_len_r;
    exp_seq_nxt   = exp_seq_r;
    skip_ka_nxt   = skip_ka_r;
    pbyte_nxt     = 8'd0;
    pvalid_nxt    = 1'b0;
    done_nxt      = 1'b0;
    status_nxt    = cbr_pkg::ST_OK;
    mlen_nxt      = '0;
    fin           = 1'b0;

    // Position restarts after each fragment end and saturates otherwise
    if (in_tlast) begin
      frag_pos_nxt = '0;
    end else if (frag_pos_r != cbr_pkg::POS_MAX) begin
      frag_pos_nxt = frag_pos_r + PW'(1);
    end else begin
      frag_pos_nxt = frag_pos_r;
    end

    unique case (phase_r)
      cbr_pkg::PH_IDLE: begin
        priority if (skip_ka_r) begin
          if (in_tlast) skip_ka_nxt = 1'b0;
        end else if (in_tdata == cbr_pkg::CMD_KEEPALIVE) begin
          if (!in_tlast) skip_ka_nxt = 1'b1;
        end else if (in_tdata == cbr_pkg::CMD_MSG) begin
          if (in_tlast) status_nxt = cbr_pkg::ST_SHORT;
          else          phase_nxt  = cbr_pkg::PH_LEN_HI;
        end else begin
          status_nxt = cbr_pkg::ST_BAD_CMD;
          if (!in_tlast) phase_nxt = cbr_pkg::PH_DRAIN;
        end
      end
      cbr_pkg::PH_LEN_HI: begin
        total_len_nxt = {in_tdata, 8'd0};
        if (in_tlast) begin
          status_nxt = cbr_pkg::ST_SHORT;
          phase_nxt  = cbr_pkg::PH_IDLE;
        end else begin
          phase_nxt  = cbr_pkg::PH_LEN_LO;
        end
      end
      cbr_pkg::PH_LEN_LO: begin
        // Clamp the declared length to the configured maximum message length
        total_len_nxt = (len_lo > max_len_r) ? max_len_r : len_lo;
        remaining_nxt = total_len_nxt;
        exp_seq_nxt   = '0;
        if (in_tlast) begin
          status_nxt = cbr_pkg::ST_SHORT;
          phase_nxt  = cbr_pkg::PH_IDLE;
        end else begin
          phase_nxt  = cbr_pkg::PH_INIT_DATA;
        end
      end
      cbr_pkg::PH_INIT_DATA, cbr_pkg::PH_CONT_DATA: begin
        // Drop bytes past the fragment size silently
        if (frag_pos_r < fsize) begin
          if (remaining_r == '0) begin
            fin = 1'b1;
          end else begin
            pbyte_nxt     = in_tdata;
            pvalid_nxt    = 1'b1;
            remaining_nxt = remaining_r - LW'(1);
            fin           = (remaining_r == LW'(1));
          end
        end
        if (fin) begin
          done_nxt  = 1'b1;
          mlen_nxt  = total_len_r;
          phase_nxt = in_tlast ? cbr_pkg::PH_IDLE : cbr_pkg::PH_DRAIN;
        end else if (in_tlast) begin
          phase_nxt = cbr_pkg::PH_CONT_SEQ;
        end
      end
      cbr_pkg::PH_CONT_SEQ: begin
        // Short fragment wins over the sequence check
        priority if (in_tlast) begin
          status_nxt = cbr_pkg::ST_SHORT;
          phase_nxt  = cbr_pkg::PH_IDLE;
        end else if (in_tdata != {1'b0, exp_seq_r}) begin
          status_nxt = cbr_pkg::ST_SEQ;
          phase_nxt  = cbr_pkg::PH_DRAIN;
        end else begin
          exp_seq_nxt = exp_seq_r + SW'(1);
          phase_nxt   = cbr_pkg::PH_CONT_DATA;
        end
      end
      cbr_pkg::PH_DRAIN: begin
        if (in_tlast) phase_nxt = cbr_pkg::PH_IDLE;
      end
      default: begin
        phase_nxt = cbr_pkg::PH_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= cbr_pkg::PH_IDLE;
      frag_pos_r  <= '0;
      remaining_r <= '0;
      total_len_r <= '0;
      exp_seq_r   <= '0;
      skip_ka_r   <= 1'b0;
    end else if (accept) begin
      phase_r     <= phase_nxt;
      frag_pos_r  <= frag_pos_nxt;
      remaining_r <= remaining_nxt;
      total_len_r <= total_len_nxt;
      exp_seq_r   <= exp_seq_nxt;
      skip_ka_r   <= skip_ka_nxt;
    end
  end

  // Result register: load on accept, hold while the sink stalls
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pbyte_r  <= pbyte_nxt;
      pvalid_r <= pvalid_nxt;
      done_r   <= done_nxt;
      status_r <= status_nxt;
      mlen_r   <= mlen_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'd0, mlen_r, status_r, done_r, pbyte_r};
  assign out_tuser  = pvalid_r;

  // Keepalive skipping only happens while waiting for an initial fragment
  a_skip_in_idle: assert property (@(posedge clk) disable iff (!rst_n)
    skip_ka_r |-> (phase_r == cbr_pkg::PH_IDLE))
    else $error("keepalive skip outside idle phase");

  // A payload byte or completion never carries an error status
  a_payload_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (pvalid_r || done_r)) |-> (status_r == cbr_pkg::ST_OK))
    else $error("payload or completion with error status");

  // Input stalls only while a result waits on a stalled sink
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (out_valid_r && !out_tready))
    else $error("input stalled without a pending result");

  // Completion reports the stored message length and leaves the data phases
  a_done_len: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && done_nxt) |=> (mlen_r == total_len_r) &&
      (phase_r == cbr_pkg::PH_IDLE || phase_r == cbr_pkg::PH_DRAIN))
    else $error("completion with wrong length or phase");

endmodule
`default_nettype wire
